// File: src/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the pinhole point projection core.
// ----------------------------------------------------------------------------
package ppp_pkg;

   // default number format, signed Q16.16
   localparam int COEF_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // camera model geometry
   localparam int MAT_DIM     = 3;
   localparam int MAT_ENTRIES = 9;
   localparam int VEC_ENTRIES = 3;

   // cycles from a load beat until the combined matrix is current
   localparam logic [1:0] LOAD_LATENCY = 2'd2;

   // what one request beat does
   typedef enum logic [1:0] {
      ACT_LOAD_INTR  = 2'd0,
      ACT_LOAD_ROT   = 2'd1,
      ACT_LOAD_TRANS = 2'd2,
      ACT_PROJECT    = 2'd3
   } action_type;

endpackage

// File: src/ppp_req_if.sv
// ----------------------------------------------------------------------------
// ppp_req_if
// Request channel: load beats and point beats, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppp_req_if import ppp_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   action_type                   action;
   logic [3:0]                   entry_index;
   logic signed [COEF_WIDTH-1:0] entry_value;
   logic signed [COEF_WIDTH-1:0] point_x;
   logic signed [COEF_WIDTH-1:0] point_y;
   logic signed [COEF_WIDTH-1:0] point_z;

   modport source (output valid, action, entry_index, entry_value,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, action, entry_index, entry_value,
                   point_x, point_y, point_z, output ready);
endinterface

// File: src/ppp_rsp_if.sv
// ----------------------------------------------------------------------------
// ppp_rsp_if
// Response channel: projected image point and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppp_rsp_if import ppp_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] image_u;
   logic signed [COEF_WIDTH-1:0] image_v;
   logic                         depth_was_zero;
   logic                         saturated;

   modport source (output valid, image_u, image_v, depth_was_zero, saturated,
                   input ready);
   modport sink   (input valid, image_u, image_v, depth_was_zero, saturated,
                   output ready);
endinterface

// File: src/pinhole_point_projection_core.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection_core
// Projects world points through m = (A*R)*p + A*T and divides by depth.
// ----------------------------------------------------------------------------
//
//   channel   | direction | beat
//   ----------+-----------+-----------------------------------------------
//   req_bus   | in        | load of A, R or T entry, or a point to project
//   rsp_bus   | out       | image_u, image_v, depth_was_zero, saturated
//
// Point beats stream at one per cycle while no load is pending and rsp_bus
// is not stalled; each result passes stages 1 to 4, the divider and the
// output register, and the divider makes one quotient bit per stage.
// A load beat blocks the request side while A*R and A*T are rebuilt, until
// busy_ff has counted down from LOAD_LATENCY; reset starts the same hold-off
// and is synchronous. A stall on rsp_bus fills bubbles, then blocks requests.
// ----------------------------------------------------------------------------
module pinhole_point_projection_core import ppp_pkg::*; #(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   ppp_req_if.sink    req_bus,
   ppp_rsp_if.source  rsp_bus
);

   localparam int C    = COEF_WIDTH;
   localparam int W_P  = 2 * C + 2;          // combined matrix entry
   localparam int W_M  = 3 * C + 5;          // homogeneous point
   localparam int WN   = W_M + FRAC_BITS;    // dividend
   localparam int WR   = WN + C;             // divider datapath
   localparam int NSTG = C + 1;              // overflow stage + quotient bits

   // coefficient stores
   logic signed [C-1:0]   a_ff [MAT_ENTRIES];
   logic signed [C-1:0]   r_ff [MAT_ENTRIES];
   logic signed [C-1:0]   t_ff [VEC_ENTRIES];

   // combined model
   logic signed [2*C-1:0] ar_prod_ff [MAT_DIM][MAT_DIM][MAT_DIM];
   logic signed [2*C-1:0] at_prod_ff [MAT_DIM][MAT_DIM];
   logic signed [W_P-1:0] mat_ff [MAT_DIM][MAT_DIM];
   logic signed [W_P-1:0] atv_ff [MAT_DIM];
   logic [1:0]            busy_ff;

   // stage 1: partial products
   logic signed [2*C:0]   plo_in [MAT_DIM][MAT_DIM];
   logic signed [2*C+1:0] phi_in [MAT_DIM][MAT_DIM];
   logic signed [2*C:0]   plo_ff [MAT_DIM][MAT_DIM];
   logic signed [2*C+1:0] phi_ff [MAT_DIM][MAT_DIM];
   logic signed [W_P-1:0] at1_ff [MAT_DIM];
   logic signed [C-1:0]   pt     [MAT_DIM];
   logic                  v1_ff;

   // stage 2: row sums
   logic signed [2*C+2:0] lo_sum_ff [MAT_DIM];
   logic signed [2*C+3:0] hi_sum_ff [MAT_DIM];
   logic signed [W_P-1:0] at2_ff    [MAT_DIM];
   logic                  v2_ff;

   // stage 3: homogeneous point
   logic signed [W_M-1:0] m_in [MAT_DIM];
   logic signed [W_M-1:0] m_ff [MAT_DIM];
   logic                  v3_ff;

   // stage 4: divider operands
   logic [W_M-1:0]        mag  [MAT_DIM];
   logic                  zero_in;
   logic [WR-1:0]         num_u_in, num_v_in, den_in;
   logic [WR-1:0]         num_u_ff, num_v_ff, den_ff;
   logic                  neg_u_ff, neg_v_ff, zero4_ff;
   logic                  v4_ff;

   // divider stages
   logic [WR-1:0]         rem_u_in [NSTG];
   logic [WR-1:0]         rem_v_in [NSTG];
   logic [C-1:0]          q_u_in   [NSTG];
   logic [C-1:0]          q_v_in   [NSTG];
   logic [WR-1:0]         den_sh   [NSTG];
   logic [WR-1:0]         rem_u_ff [NSTG];
   logic [WR-1:0]         rem_v_ff [NSTG];
   logic [C-1:0]          q_u_ff   [NSTG];
   logic [C-1:0]          q_v_ff   [NSTG];
   logic [WR-1:0]         dd_ff    [NSTG];
   logic                  ng_u_ff  [NSTG];
   logic                  ng_v_ff  [NSTG];
   logic                  ov_u_ff  [NSTG];
   logic                  ov_v_ff  [NSTG];
   logic                  zd_ff    [NSTG];
   logic                  dv_ff    [NSTG];
   logic                  ov_u_in, ov_v_in;

   // output register
   logic                  out_v_ff;
   logic signed [C-1:0]   u_ff, v_ff, u_in, v_in;
   logic                  zero_out_ff, sat_ff, sat_in;
   logic [C-1:0]          lim_u, lim_v;
   logic                  sat_u, sat_v;

   // handshake
   logic                  rdy_out, rdy1, rdy2, rdy3, rdy4;
   logic                  rdy_d [NSTG];
   logic                  load_acc, proj_acc;

   // ready chain, each stage takes a beat when empty or moving on
   always_comb begin
      rdy_out = !out_v_ff || rsp_bus.ready;
      rdy_d[NSTG-1] = !dv_ff[NSTG-1] || rdy_out;
      for (int k = NSTG - 2; k >= 0; k--) begin
         rdy_d[k] = !dv_ff[k] || rdy_d[k+1];
      end
      rdy4 = !v4_ff || rdy_d[0];
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   assign req_bus.ready = (busy_ff == 2'd0) && rdy1;
   assign load_acc = req_bus.valid && req_bus.ready && (req_bus.action != ACT_PROJECT);
   assign proj_acc = req_bus.valid && req_bus.ready && (req_bus.action == ACT_PROJECT);

   // coefficient writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_ENTRIES; i++) begin
            a_ff[i] <= '0;
            r_ff[i] <= '0;
         end
         for (int i = 0; i < VEC_ENTRIES; i++) begin
            t_ff[i] <= '0;
         end
      end else if (load_acc) begin
         case (req_bus.action)
            ACT_LOAD_INTR: begin
               if (req_bus.entry_index < MAT_ENTRIES) begin
                  a_ff[req_bus.entry_index] <= req_bus.entry_value;
               end
            end
            ACT_LOAD_ROT: begin
               if (req_bus.entry_index < MAT_ENTRIES) begin
                  r_ff[req_bus.entry_index] <= req_bus.entry_value;
               end
            end
            ACT_LOAD_TRANS: begin
               if (req_bus.entry_index < VEC_ENTRIES) begin
                  t_ff[req_bus.entry_index[1:0]] <= req_bus.entry_value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // hold off requests while the combined model catches up
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= LOAD_LATENCY;
      end else if (load_acc) begin
         busy_ff <= LOAD_LATENCY;
      end else if (busy_ff != 2'd0) begin
         busy_ff <= busy_ff - 2'd1;
      end
   end

   // A*R and A*T, products then sums, rebuilt every cycle
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAT_DIM; i++) begin
         for (int k = 0; k < MAT_DIM; k++) begin
            at_prod_ff[i][k] <= a_ff[i*MAT_DIM+k] * t_ff[k];
            for (int j = 0; j < MAT_DIM; j++) begin
               ar_prod_ff[i][j][k] <= a_ff[i*MAT_DIM+k] * r_ff[k*MAT_DIM+j];
            end
         end
         atv_ff[i] <= W_P'(at_prod_ff[i][0]) + W_P'(at_prod_ff[i][1])
                      + W_P'(at_prod_ff[i][2]);
         for (int j = 0; j < MAT_DIM; j++) begin
            mat_ff[i][j] <= W_P'(ar_prod_ff[i][j][0]) + W_P'(ar_prod_ff[i][j][1])
                            + W_P'(ar_prod_ff[i][j][2]);
         end
      end
   end

   // stage 1: each matrix entry split in low and high halves times the point
   always_comb begin
      pt[0] = req_bus.point_x;
      pt[1] = req_bus.point_y;
      pt[2] = req_bus.point_z;
      for (int i = 0; i < MAT_DIM; i++) begin
         for (int j = 0; j < MAT_DIM; j++) begin
            plo_in[i][j] = $signed({1'b0, mat_ff[i][j][C-1:0]}) * pt[j];
            phi_in[i][j] = $signed(mat_ff[i][j][W_P-1:C]) * pt[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= proj_acc;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         at1_ff <= atv_ff;
      end
      // stage 2: row sums
      if (rdy2) begin
         for (int i = 0; i < MAT_DIM; i++) begin
            lo_sum_ff[i] <= (2*C+3)'(plo_ff[i][0]) + (2*C+3)'(plo_ff[i][1])
                            + (2*C+3)'(plo_ff[i][2]);
            hi_sum_ff[i] <= (2*C+4)'(phi_ff[i][0]) + (2*C+4)'(phi_ff[i][1])
                            + (2*C+4)'(phi_ff[i][2]);
         end
         at2_ff <= at1_ff;
      end
      if (rdy3) m_ff <= m_in;
      if (rdy4) begin
         num_u_ff <= num_u_in;
         num_v_ff <= num_v_in;
         den_ff   <= den_in;
         neg_u_ff <= m_ff[0][W_M-1] ^ m_ff[2][W_M-1];
         neg_v_ff <= m_ff[1][W_M-1] ^ m_ff[2][W_M-1];
         zero4_ff <= zero_in;
      end
   end

   // stage 3: recombine halves and add translation at 3F fraction bits
   always_comb begin
      for (int i = 0; i < MAT_DIM; i++) begin
         m_in[i] = (W_M'(hi_sum_ff[i]) <<< C) + W_M'(lo_sum_ff[i])
                   + (W_M'(at2_ff[i]) <<< FRAC_BITS);
      end
   end

   // stage 4: magnitudes and divider operands
   always_comb begin
      for (int i = 0; i < MAT_DIM; i++) begin
         mag[i] = m_ff[i][W_M-1] ? W_M'(-m_ff[i]) : W_M'(m_ff[i]);
      end
      zero_in = (m_ff[2] == '0);
      if (zero_in) begin
         // no depth: scale 3F down to F fraction bits
         num_u_in = WR'(mag[0]);
         num_v_in = WR'(mag[1]);
         den_in   = WR'(1) << (2 * FRAC_BITS);
      end else begin
         num_u_in = WR'(mag[0]) << FRAC_BITS;
         num_v_in = WR'(mag[1]) << FRAC_BITS;
         den_in   = WR'(mag[2]);
      end
   end

   // divider: overflow check first, then one quotient bit per stage
   always_comb begin
      ov_u_in     = num_u_ff >= (den_ff << C);
      ov_v_in     = num_v_ff >= (den_ff << C);
      rem_u_in[0] = num_u_ff;
      rem_v_in[0] = num_v_ff;
      q_u_in[0]   = '0;
      q_v_in[0]   = '0;
      den_sh[0]   = '0;
      for (int j = 1; j < NSTG; j++) begin
         den_sh[j] = dd_ff[j-1] << (C - j);
         if (rem_u_ff[j-1] >= den_sh[j]) begin
            rem_u_in[j] = rem_u_ff[j-1] - den_sh[j];
            q_u_in[j]   = q_u_ff[j-1] | (C'(1) << (C - j));
         end else begin
            rem_u_in[j] = rem_u_ff[j-1];
            q_u_in[j]   = q_u_ff[j-1];
         end
         if (rem_v_ff[j-1] >= den_sh[j]) begin
            rem_v_in[j] = rem_v_ff[j-1] - den_sh[j];
            q_v_in[j]   = q_v_ff[j-1] | (C'(1) << (C - j));
         end else begin
            rem_v_in[j] = rem_v_ff[j-1];
            q_v_in[j]   = q_v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NSTG; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else begin
         if (rdy_d[0]) dv_ff[0] <= v4_ff;
         for (int j = 1; j < NSTG; j++) begin
            if (rdy_d[j]) dv_ff[j] <= dv_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d[0]) begin
         rem_u_ff[0] <= rem_u_in[0];
         rem_v_ff[0] <= rem_v_in[0];
         q_u_ff[0]   <= q_u_in[0];
         q_v_ff[0]   <= q_v_in[0];
         dd_ff[0]    <= den_ff;
         ng_u_ff[0]  <= neg_u_ff;
         ng_v_ff[0]  <= neg_v_ff;
         ov_u_ff[0]  <= ov_u_in;
         ov_v_ff[0]  <= ov_v_in;
         zd_ff[0]    <= zero4_ff;
      end
      for (int j = 1; j < NSTG; j++) begin
         if (rdy_d[j]) begin
            rem_u_ff[j] <= rem_u_in[j];
            rem_v_ff[j] <= rem_v_in[j];
            q_u_ff[j]   <= q_u_in[j];
            q_v_ff[j]   <= q_v_in[j];
            dd_ff[j]    <= dd_ff[j-1];
            ng_u_ff[j]  <= ng_u_ff[j-1];
            ng_v_ff[j]  <= ng_v_ff[j-1];
            ov_u_ff[j]  <= ov_u_ff[j-1];
            ov_v_ff[j]  <= ov_v_ff[j-1];
            zd_ff[j]    <= zd_ff[j-1];
         end
      end
   end

   // clamp to the signed range, negative side reaches one further
   always_comb begin
      lim_u = {1'b0, {(C-1){1'b1}}} + C'(ng_u_ff[NSTG-1]);
      lim_v = {1'b0, {(C-1){1'b1}}} + C'(ng_v_ff[NSTG-1]);
      sat_u = ov_u_ff[NSTG-1] || (q_u_ff[NSTG-1] > lim_u);
      sat_v = ov_v_ff[NSTG-1] || (q_v_ff[NSTG-1] > lim_v);
      u_in  = $signed(ng_u_ff[NSTG-1] ? -(sat_u ? lim_u : q_u_ff[NSTG-1])
                                      :  (sat_u ? lim_u : q_u_ff[NSTG-1]));
      v_in  = $signed(ng_v_ff[NSTG-1] ? -(sat_v ? lim_v : q_v_ff[NSTG-1])
                                      :  (sat_v ? lim_v : q_v_ff[NSTG-1]));
      sat_in = sat_u || sat_v;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy_out) begin
         out_v_ff <= dv_ff[NSTG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         u_ff        <= u_in;
         v_ff        <= v_in;
         zero_out_ff <= zd_ff[NSTG-1];
         sat_ff      <= sat_in;
      end
   end

   assign rsp_bus.valid          = out_v_ff;
   assign rsp_bus.image_u        = u_ff;
   assign rsp_bus.image_v        = v_ff;
   assign rsp_bus.depth_was_zero = zero_out_ff;
   assign rsp_bus.saturated      = sat_ff;

endmodule
